FILE: rtl/core/ptq_pkg.sv
`timescale 1ns / 1ps
// ptq_pkg: shared types and constants for the priority task queue.
// Used by ptq_entry_ram and priority_task_queue; depends on nothing.

package ptq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_VIEW   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_INS_HEAD,
    S_SCN_RD,
    S_SCN_WR,
    S_VIEW_RD,
    S_VIEW_WR,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] task_id;
    logic [7:0]  priority_req;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [7:0]  out_priority;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
  } entry_t;

endpackage

FILE: rtl/core/ptq_entry_ram.sv
`timescale 1ns / 1ps
// ptq_entry_ram: entry store, one write and one registered read per cycle.
// Depends on ptq_pkg for entry_t and the depth.

module ptq_entry_ram
  import ptq_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [CAPACITY];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/priority_task_queue.sv
`timescale 1ns / 1ps
// priority_task_queue: bounded sorted-list priority queue, top level.
// Depends on ptq_pkg and ptq_entry_ram.
//
// Usage:
//   in_* channel carries one command beat (insert, pop, remove by id, view).
//   out_* channel returns result beats; out_data.last marks the final beat
//   of a command. View on a non-empty queue returns one beat per stored
//   entry; everything else returns exactly one beat.
//   Entries live in a single-port-read RAM; a small sequencer walks it one
//   entry at a time (issue read, then compare and write back through the
//   shared compare unit, or emit the entry on a view), shifting entries as it goes.
// Steps (n = stored entries):
//   insert into empty / full, or any command on empty queue: straight to emit.
//   insert: from the tail, move up each entry below the new priority, then
//     write the new entry; a separate head step writes it when all n move.
//   pop / remove: read and compare each entry, shifting later ones down.
//   view: read and emit each entry in turn, pausing while the receiver stalls.
//   A new command is taken only in idle; the result register lets the
//   block take it while the last beat of the previous one still waits.
// Reset: queue empties, no result pending; RAM contents are not cleared.
// Stall: out_stall holds the result register; a view walk pauses, and other
//   commands wait in the emit step, until the pending beat is taken.

module priority_task_queue
  import ptq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [15:0]      id_r, id_nxt;
  logic [7:0]       prio_r, prio_nxt;
  logic             found_r, found_nxt;
  entry_t           hit_r, hit_nxt;
  out_t             res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  logic             ram_wr_en, ram_rd_en;
  logic [IDX_W-1:0] ram_wr_addr, ram_rd_addr;
  entry_t           ram_wr_data, ram_rd_data;

  logic   in_fire, out_free, out_load, cmp_hit, scan_last, is_full, is_empty;
  cmd_t   in_cmd;
  out_t   out_load_data;
  entry_t new_entry;

  ptq_entry_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign in_cmd    = cmd_t'(in_data.command);
  assign out_free  = !out_valid_r || !out_stall;
  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign is_empty  = (count_r == '0);
  assign scan_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign new_entry = '{id: id_r, prio: prio_r};

  // shared compare unit: priority order on insert, id match on scan (pop hits the head)
  always_comb begin
    if (state_r == S_INS_WR) begin
      cmp_hit = (ram_rd_data.prio >= prio_r);
    end else begin
      cmp_hit = (cmd_r == CMD_POP) || (ram_rd_data.id == id_r);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_cmd == CMD_INSERT) begin
            state_nxt = (is_full || is_empty) ? S_EMIT : S_INS_RD;
          end else if (is_empty) begin
            state_nxt = S_EMIT;
          end else if (in_cmd == CMD_VIEW) begin
            state_nxt = S_VIEW_RD;
          end else begin
            state_nxt = S_SCN_RD;
          end
        end
      end
      S_INS_RD: state_nxt = S_INS_WR;
      S_INS_WR: begin
        if (cmp_hit) begin
          state_nxt = S_EMIT;
        end else if (idx_r == '0) begin
          state_nxt = S_INS_HEAD;
        end else begin
          state_nxt = S_INS_RD;
        end
      end
      S_INS_HEAD: state_nxt = S_EMIT;
      S_SCN_RD:   state_nxt = S_SCN_WR;
      S_SCN_WR:   state_nxt = scan_last ? S_EMIT : S_SCN_RD;
      S_VIEW_RD:  state_nxt = S_VIEW_WR;
      S_VIEW_WR: begin
        if (out_free) begin
          state_nxt = scan_last ? S_IDLE : S_VIEW_RD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    prio_nxt      = prio_r;
    found_nxt     = found_r;
    hit_nxt       = hit_r;
    res_nxt       = res_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = idx_r;
    ram_wr_data   = new_entry;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = idx_r;
    out_load      = 1'b0;
    out_load_data = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = in_cmd;
          id_nxt    = in_data.task_id;
          prio_nxt  = in_data.priority_req;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          res_nxt   = '{status: STAT_OK, out_id: '0, out_priority: '0, last: 1'b1};
          if (in_cmd == CMD_INSERT) begin
            if (is_full) begin
              res_nxt.status = STAT_FULL;
            end else if (is_empty) begin
              ram_wr_en   = 1'b1;
              ram_wr_addr = '0;
              ram_wr_data = '{id: in_data.task_id, prio: in_data.priority_req};
              count_nxt   = count_r + CNT_W'(1);
            end else begin
              idx_nxt = IDX_W'(count_r - CNT_W'(1));
            end
          end else if (is_empty) begin
            res_nxt.status = STAT_EMPTY;
          end
        end
      end
      S_INS_RD, S_SCN_RD, S_VIEW_RD: begin
        ram_rd_en = 1'b1;
      end
      S_INS_WR: begin
        // walk from the tail; entries below the new priority move up one
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx_r + IDX_W'(1);
        if (cmp_hit) begin
          count_nxt = count_r + CNT_W'(1);
        end else begin
          ram_wr_data = ram_rd_data;
          idx_nxt     = idx_r - IDX_W'(1);
        end
      end
      S_INS_HEAD: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = '0;
        count_nxt   = count_r + CNT_W'(1);
      end
      S_SCN_WR: begin
        // after the hit, every later entry moves down one
        if (found_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = idx_r - IDX_W'(1);
          ram_wr_data = ram_rd_data;
        end else if (cmp_hit) begin
          found_nxt = 1'b1;
          hit_nxt   = ram_rd_data;
        end
        if (scan_last) begin
          if (found_r || cmp_hit) begin
            count_nxt           = count_r - CNT_W'(1);
            res_nxt.status      = STAT_OK;
            res_nxt.out_id      = found_r ? hit_r.id : ram_rd_data.id;
            res_nxt.out_priority = found_r ? hit_r.prio : ram_rd_data.prio;
          end else begin
            res_nxt.status = STAT_NOT_FOUND;
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_VIEW_WR: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_load_data = '{status: STAT_OK, out_id: ram_rd_data.id,
                            out_priority: ram_rd_data.prio, last: scan_last};
          idx_nxt       = idx_r + IDX_W'(1);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = out_load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cmd_r      <= cmd_nxt;
    id_r       <= id_nxt;
    prio_r     <= prio_nxt;
    found_r    <= found_nxt;
    hit_r      <= hit_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CNT_W'(1) || count_r + CNT_W'(1) == $past(count_r)))
    else $error("entry count moved by more than one");

  a_shift_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_WR || state_r == S_INS_HEAD) |-> !is_full)
    else $error("insert walk on a full queue");

  a_scan_hit_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCN_WR && found_r) |-> (idx_r != '0))
    else $error("shift-down below head");

  a_view_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VIEW_WR || state_r == S_SCN_WR) |-> !is_empty)
    else $error("walk over an empty queue");

endmodule
